// ===== sv/sha1md_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_pkg
// shared types and constants of the sha-1 digest unit
// ----------------------------------------------------------------------------
package sha1md_pkg;

   typedef logic [31:0] word_type;

   // working variables of one compression
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } work_type;

   localparam word_type Iv0 = 32'h6745_2301;
   localparam word_type Iv1 = 32'hEFCD_AB89;
   localparam word_type Iv2 = 32'h98BA_DCFE;
   localparam word_type Iv3 = 32'h1032_5476;
   localparam word_type Iv4 = 32'hC3D2_E1F0;

   localparam word_type K0 = 32'h5A82_7999;
   localparam word_type K1 = 32'h6ED9_EBA1;
   localparam word_type K2 = 32'h8F1B_BCDC;
   localparam word_type K3 = 32'hCA62_C1D6;

   localparam logic [6:0] LastRound   = 7'd79;
   localparam logic [6:0] Phase1Start = 7'd20;
   localparam logic [6:0] Phase2Start = 7'd40;
   localparam logic [6:0] Phase3Start = 7'd60;

   localparam logic [7:0] PadMark = 8'h80;
   localparam logic [5:0] LenPos  = 6'd56;

   // initial chaining word for an entry not yet written
   function automatic word_type init_word(input logic [2:0] idx);
      word_type r;
      unique case (idx)
         3'd0:    r = Iv0;
         3'd1:    r = Iv1;
         3'd2:    r = Iv2;
         3'd3:    r = Iv3;
         3'd4:    r = Iv4;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/sha1md_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1md_round
// one sha-1 round: round function, constant select and working update
// ----------------------------------------------------------------------------
module sha1md_round (
   input  sha1md_pkg::work_type cur,
   input  sha1md_pkg::word_type w,
   input  logic [6:0]           round,
   output sha1md_pkg::work_type nxt
);

   sha1md_pkg::word_type f;
   sha1md_pkg::word_type k;

   always_comb begin
      priority if (round < sha1md_pkg::Phase1Start) begin
         f = (cur.b & cur.c) | (~cur.b & cur.d);
         k = sha1md_pkg::K0;
      end else if (round < sha1md_pkg::Phase2Start) begin
         f = cur.b ^ cur.c ^ cur.d;
         k = sha1md_pkg::K1;
      end else if (round < sha1md_pkg::Phase3Start) begin
         f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
         k = sha1md_pkg::K2;
      end else begin
         f = cur.b ^ cur.c ^ cur.d;
         k = sha1md_pkg::K3;
      end
   end

   always_comb begin
      nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
      nxt.b = cur.a;
      nxt.c = {cur.b[1:0], cur.b[31:2]};
      nxt.d = cur.c;
      nxt.e = cur.d;
   end

endmodule

// ===== sv/sha1_message_digest_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_digest_unit
// byte-serial sha-1 hashing with automatic padding and digest output
// ----------------------------------------------------------------------------
// A message arrives one word per accepted request, each carrying at most one
// byte; a word flagged end_of_message finishes the message (its byte, if any,
// is absorbed first) and later yields one response with the 160-bit digest,
// digest_word0 most significant. A plain byte word is taken while the unit is idle.
// Every 64th byte starts a compression that keeps the request side stalled
// while it reads the chaining words, runs 80 rounds at one round per cycle
// through a single round unit and writes the sums back. Finishing a message
// appends padding at one byte per cycle, paused while a compression runs
// (9 to 72 bytes), takes one or two compressions and reads the digest out.
// The chaining words live in a 5-entry memory with per-entry valid bits
// (an invalid entry reads as the initial value), and the block's message
// words in a 16-entry memory. A finished digest waits in the response
// registers while the next message is already taken in.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4
);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;  // taking message words
   localparam logic [2:0] S_PAD   = 3'd1;  // appending padding bytes
   localparam logic [2:0] S_LDH   = 3'd2;  // loading chaining words
   localparam logic [2:0] S_RND   = 3'd3;  // compression rounds
   localparam logic [2:0] S_WB    = 3'd4;  // chaining write-back
   localparam logic [2:0] S_DRAIN = 3'd5;  // digest readout

   localparam logic [6:0] ChainLast = 7'd5;   // last step of a 5-entry sweep
   localparam logic [6:0] SchedLoad = 7'd16;  // rounds fed from block memory

   // control registers
   logic [2:0]  state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic        pad_ff, pad_in;       // padding owed for this message
   logic        mark_ff, mark_in;     // 0x80 marker still to go
   logic        wrap_ff, wrap_in;     // marker landed in the length slot
   logic        final_ff, final_in;   // last length byte written
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  chain_vld_ff, chain_vld_in;

   // datapath registers
   logic [23:0]          acc_ff, acc_in;   // leading bytes of the current word
   sha1md_pkg::work_type work_ff, work_in;
   sha1md_pkg::word_type sw_ff [0:15];
   sha1md_pkg::word_type sw_in [0:15];
   sha1md_pkg::word_type dig_ff [0:4];
   sha1md_pkg::word_type dig_in [0:4];

   // chaining word memory
   sha1md_pkg::word_type chain_mem [0:4];
   logic                 chain_we;
   logic [2:0]           chain_waddr;
   sha1md_pkg::word_type chain_wdata;
   logic [2:0]           chain_raddr;
   sha1md_pkg::word_type chain_q_ff;
   logic                 chain_vq_ff;
   logic [2:0]           chain_ridx_ff;
   sha1md_pkg::word_type chain_rd;

   // message block memory
   sha1md_pkg::word_type blk_mem [0:15];
   logic                 blk_we;
   logic [3:0]           blk_waddr;
   sha1md_pkg::word_type blk_wdata;
   logic [3:0]           blk_raddr;
   sha1md_pkg::word_type blk_q_ff;

   // byte insertion and round datapath
   logic                 put_en;
   logic [7:0]           put_val;
   logic [63:0]          bit_len;
   logic [7:0]           len_byte;
   sha1md_pkg::word_type w_mix;
   sha1md_pkg::word_type w_t;
   sha1md_pkg::work_type round_nxt;

   always_ff @(posedge clock) begin
      if (chain_we) begin
         chain_mem[chain_waddr] <= chain_wdata;
      end
      chain_q_ff    <= chain_mem[chain_raddr];
      chain_vq_ff   <= chain_vld_ff[chain_raddr];
      chain_ridx_ff <= chain_raddr;
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      blk_q_ff <= blk_mem[blk_raddr];
   end

   // unwritten chaining entries read as the initial values
   assign chain_rd = chain_vq_ff ? chain_q_ff : sha1md_pkg::init_word(chain_ridx_ff);

   assign bit_len  = {count_ff, 3'b000};
   assign len_byte = bit_len[{~fill_ff[2:0], 3'b000} +: 8];

   // schedule expansion from the 16-word window
   assign w_mix = sw_ff[13] ^ sw_ff[8] ^ sw_ff[2] ^ sw_ff[0];
   assign w_t   = (cnt_ff < SchedLoad) ? blk_q_ff : {w_mix[30:0], w_mix[31]};

   sha1md_round u_round (
      .cur   (work_ff),
      .w     (w_t),
      .round (cnt_ff),
      .nxt   (round_nxt)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      pad_in       = pad_ff;
      mark_in      = mark_ff;
      wrap_in      = wrap_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff;
      chain_vld_in = chain_vld_ff;
      acc_in       = acc_ff;
      work_in      = work_ff;
      sw_in        = sw_ff;
      dig_in       = dig_ff;
      chain_we     = 1'b0;
      chain_waddr  = '0;
      chain_wdata  = work_ff.a;
      chain_raddr  = '0;
      blk_raddr    = '0;
      put_en       = 1'b0;
      put_val      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_has_byte) begin
                  put_en   = 1'b1;
                  put_val  = req_data_byte;
                  count_in = count_ff + 61'd1;
               end
               if (req_end_of_message) begin
                  pad_in   = 1'b1;
                  mark_in  = 1'b1;
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            put_en = 1'b1;
            if (mark_ff) begin
               put_val = sha1md_pkg::PadMark;
               mark_in = 1'b0;
               // marker inside the length slot: zero fill runs into next block
               wrap_in = (fill_ff >= sha1md_pkg::LenPos) && (fill_ff != 6'd63);
            end else if ((fill_ff >= sha1md_pkg::LenPos) && !wrap_ff) begin
               put_val = len_byte;
               if (fill_ff == 6'd63) begin
                  final_in = 1'b1;
               end
            end else begin
               put_val = '0;
            end
         end
         S_LDH: begin
            if (cnt_ff < ChainLast) begin
               chain_raddr = cnt_ff[2:0];
            end
            if (cnt_ff != '0) begin
               work_in = {work_ff.b, work_ff.c, work_ff.d, work_ff.e, chain_rd};
            end
            if (cnt_ff == ChainLast) begin
               blk_raddr = '0;
               cnt_in    = '0;
               state_in  = S_RND;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_RND: begin
            if (cnt_ff < (SchedLoad - 7'd1)) begin
               blk_raddr = cnt_ff[3:0] + 4'd1;
            end
            work_in = round_nxt;
            for (int i = 0; i < 15; i++) begin
               sw_in[i] = sw_ff[i + 1];
            end
            sw_in[15] = w_t;
            if (cnt_ff == sha1md_pkg::LastRound) begin
               cnt_in   = '0;
               state_in = S_WB;
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_WB: begin
            if (cnt_ff < ChainLast) begin
               chain_raddr = cnt_ff[2:0];
            end
            if (cnt_ff != '0) begin
               chain_we    = 1'b1;
               chain_waddr = cnt_ff[2:0] - 3'd1;
               chain_wdata = chain_rd + work_ff.a;
               chain_vld_in[chain_waddr] = 1'b1;
               work_in = {work_ff.b, work_ff.c, work_ff.d, work_ff.e, work_ff.a};
            end
            if (cnt_ff == ChainLast) begin
               cnt_in = '0;
               priority if (final_ff) begin
                  state_in = S_DRAIN;
               end else if (pad_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + 7'd1;
            end
         end
         S_DRAIN: begin
            // start only once the response registers are free
            if (!((cnt_ff == '0) && rsp_valid_ff)) begin
               if (cnt_ff < ChainLast) begin
                  chain_raddr = cnt_ff[2:0];
               end
               if (cnt_ff != '0) begin
                  for (int i = 0; i < 4; i++) begin
                     dig_in[i] = dig_ff[i + 1];
                  end
                  dig_in[4] = chain_rd;
               end
               if (cnt_ff == ChainLast) begin
                  rsp_valid_in = 1'b1;
                  chain_vld_in = '0;
                  count_in     = '0;
                  pad_in       = 1'b0;
                  final_in     = 1'b0;
                  cnt_in       = '0;
                  state_in     = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + 7'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // byte packing into the block memory, compression on a full block
      blk_we    = 1'b0;
      blk_waddr = fill_ff[5:2];
      blk_wdata = {acc_ff, put_val};
      if (put_en) begin
         if (fill_ff[1:0] == 2'd3) begin
            blk_we = 1'b1;
         end else begin
            acc_in = {acc_ff[15:0], put_val};
         end
         fill_in = fill_ff + 6'd1;
         if (fill_ff == 6'd63) begin
            wrap_in  = 1'b0;
            cnt_in   = '0;
            state_in = S_LDH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         pad_ff       <= 1'b0;
         mark_ff      <= 1'b0;
         wrap_ff      <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chain_vld_ff <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         pad_ff       <= pad_in;
         mark_ff      <= mark_in;
         wrap_ff      <= wrap_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         chain_vld_ff <= chain_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      work_ff <= work_in;
      sw_ff   <= sw_in;
      dig_ff  <= dig_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_digest_word0 = dig_ff[0];
   assign rsp_digest_word1 = dig_ff[1];
   assign rsp_digest_word2 = dig_ff[2];
   assign rsp_digest_word3 = dig_ff[3];
   assign rsp_digest_word4 = dig_ff[4];

   // a compression only ever starts on a full block
   a_start_on_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LDH && $past(state_ff) != S_LDH) |-> $past(fill_ff) == 6'd63)
      else $error("compression started on a partial block");

   // the digest is read out only with the block emptied and padding done
   a_drain_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN) |-> (fill_ff == '0 && !mark_ff && !wrap_ff && final_ff))
      else $error("digest readout with padding incomplete");

   // a response appears only at the end of a readout
   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DRAIN)
      else $error("response raised outside digest readout");

   // the round counter stays within the eighty rounds
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RND) |-> cnt_ff <= sha1md_pkg::LastRound)
      else $error("round counter out of range");

   // the last length byte only appears while padding a message
   a_final_pad: assert property (@(posedge clock) disable iff (reset)
      final_ff |-> pad_ff)
      else $error("length written outside padding");

endmodule
